[rtl/core/fsce_pkg.sv]
// Shared types and constants for the sector chain engine.
`timescale 1ns / 1ps
package fsce_pkg;

   localparam int SECTORS_PER_TRACK    = 60;
   localparam int SECTORS_PER_CYLINDER = 300;
   localparam int TABLE_DEPTH          = 3000;
   localparam int MAX_FILES            = 64;

   localparam int LATENCY_TIME  = 6;
   localparam int SEEK_TIME     = 4;
   localparam int TRANSFER_TIME = 12;

   localparam int FUNC_W = 2;
   localparam int FID_W  = 6;
   localparam int CYL_W  = 4;
   localparam int TRK_W  = 3;
   localparam int SEC_W  = 6;
   localparam int POS_W  = 12;
   localparam int LEN_W  = 12;
   localparam int TPS_W  = 8;
   localparam int TIME_W = 20;
   localparam int RAW_POS_W = $clog2(SECTORS_PER_CYLINDER * (2 ** CYL_W) +
                                     SECTORS_PER_TRACK * (2 ** TRK_W) + (2 ** SEC_W));

   localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(LATENCY_TIME + SEEK_TIME + TRANSFER_TIME);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CREATE = 2'd0,
      FUNC_APPEND = 2'd1,
      FUNC_REMOVE = 2'd2,
      FUNC_QUERY  = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_PUT_NEW,
      ST_PUT_LINK,
      ST_WALK_START,
      ST_WALK,
      ST_CALC,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic             has_next;
      logic [POS_W-1:0] next;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [POS_W-1:0] addr;
      entry_type        data;
   } tbl_wr_type;

endpackage

[rtl/core/fsce_table.sv]
// Sector link table: one write port, one registered read port with write forwarding.
`timescale 1ns / 1ps
module fsce_table (
   input  logic                           clock,
   input  fsce_pkg::tbl_wr_type           wr,
   input  logic [fsce_pkg::POS_W-1:0]     rd_addr,
   output fsce_pkg::entry_type            rd_data
);

   fsce_pkg::entry_type mem_ff [fsce_pkg::TABLE_DEPTH];
   fsce_pkg::entry_type rd_ff;
   fsce_pkg::entry_type fwd_ff;
   logic                hit_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_ff  <= mem_ff[rd_addr];
      fwd_ff <= wr.data;
      hit_ff <= wr.en && (wr.addr == rd_addr);
   end

   assign rd_data = hit_ff ? fwd_ff : rd_ff;

endmodule

[rtl/core/fat_sector_chain_engine.sv]
// Top level: directory, open-chain tail and chain-walking sequencer.
// Create/append look up the directory, then write the table (rejects go straight to the
// response); remove/query walk the chain, one table entry per cycle, if the file exists.
// One item at a time; req_ready returns the cycle after the result is taken.
// Reset is synchronous; a table clearing pass over every entry follows with req_ready low.
`timescale 1ns / 1ps
module fat_sector_chain_engine (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [fsce_pkg::FUNC_W-1:0]      req_func,
   input  logic [fsce_pkg::FID_W-1:0]       req_file_id,
   input  logic [fsce_pkg::CYL_W-1:0]       req_cylinder,
   input  logic [fsce_pkg::TRK_W-1:0]       req_track,
   input  logic [fsce_pkg::SEC_W-1:0]       req_sector_in_track,
   input  logic                             req_last_sector,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_ok,
   output logic                             rsp_found,
   output logic [fsce_pkg::POS_W-1:0]       rsp_start_position,
   output logic [fsce_pkg::LEN_W-1:0]       rsp_chain_length,
   output logic [fsce_pkg::TIME_W-1:0]      rsp_read_time,
   input  logic                             csr_write_enable,
   input  logic [fsce_pkg::TPS_W-1:0]       csr_write_data
);

   fsce_pkg::state_type state_ff, state_in;
   logic [fsce_pkg::POS_W-1:0]     clr_ff, clr_in;
   fsce_pkg::func_type             func_ff, func_in;
   logic [fsce_pkg::FID_W-1:0]     fid_ff, fid_in;
   logic [fsce_pkg::RAW_POS_W-1:0] pos_ff, pos_in;
   logic                           eof_ff, eof_in;
   logic                           found_ff, found_in;
   logic [fsce_pkg::POS_W-1:0]     start_ff, start_in;
   logic [fsce_pkg::POS_W-1:0]     cur_ff, cur_in;
   logic [fsce_pkg::LEN_W-1:0]     len_ff, len_in;
   logic                           ok_ff, ok_in;
   logic [fsce_pkg::TIME_W-1:0]    rtime_ff, rtime_in;
   logic                           tail_valid_ff, tail_valid_in;
   logic [fsce_pkg::POS_W-1:0]     tail_pos_ff, tail_pos_in;
   logic [fsce_pkg::TPS_W-1:0]     tps_ff, tps_in;
   logic [fsce_pkg::MAX_FILES-1:0] dir_valid_ff, dir_valid_in;
   logic [fsce_pkg::POS_W-1:0]     dir_mem_ff [fsce_pkg::MAX_FILES];
   logic [fsce_pkg::POS_W-1:0]     dir_rd_ff;

   logic                           accept;
   logic                           pos_ok;
   logic                           found_now;
   logic                           dir_we;
   logic [fsce_pkg::LEN_W:0]       len_next;
   logic                           walk_more;
   logic                           tail_upd;

   fsce_pkg::tbl_wr_type           tbl_wr;
   logic [fsce_pkg::POS_W-1:0]     tbl_raddr;
   fsce_pkg::entry_type            tbl_rd;

   fsce_table u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rd)
   );

   assign accept    = req_valid && req_ready;
   assign pos_ok    = pos_ff < fsce_pkg::RAW_POS_W'(fsce_pkg::TABLE_DEPTH);
   assign found_now = dir_valid_ff[fid_ff];
   assign len_next  = {1'b0, len_ff} + 1'b1;
   assign walk_more = tbl_rd.has_next && (len_next < (fsce_pkg::LEN_W + 1)'(fsce_pkg::TABLE_DEPTH));
   assign tail_upd  = ((state_ff == fsce_pkg::ST_PUT_NEW) && !tail_valid_ff) ||
                      (state_ff == fsce_pkg::ST_PUT_LINK);
   assign dir_we    = (state_ff == fsce_pkg::ST_LOOKUP) && (func_ff == fsce_pkg::FUNC_CREATE) &&
                      !found_now && pos_ok;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fsce_pkg::ST_CLEAR: begin
            if (clr_ff == fsce_pkg::POS_W'(fsce_pkg::TABLE_DEPTH - 1)) begin
               state_in = fsce_pkg::ST_IDLE;
            end
         end
         fsce_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = fsce_pkg::ST_LOOKUP;
            end
         end
         fsce_pkg::ST_LOOKUP: begin
            case (func_ff)
               fsce_pkg::FUNC_CREATE: begin
                  state_in = (!found_now && pos_ok) ? fsce_pkg::ST_PUT_NEW : fsce_pkg::ST_RESP;
               end
               fsce_pkg::FUNC_APPEND: begin
                  state_in = pos_ok ? fsce_pkg::ST_PUT_NEW : fsce_pkg::ST_RESP;
               end
               fsce_pkg::FUNC_REMOVE: begin
                  state_in = found_now ? fsce_pkg::ST_WALK_START : fsce_pkg::ST_RESP;
               end
               default: begin
                  state_in = found_now ? fsce_pkg::ST_WALK_START : fsce_pkg::ST_CALC;
               end
            endcase
         end
         fsce_pkg::ST_PUT_NEW: begin
            state_in = tail_valid_ff ? fsce_pkg::ST_PUT_LINK : fsce_pkg::ST_RESP;
         end
         fsce_pkg::ST_PUT_LINK: begin
            state_in = fsce_pkg::ST_RESP;
         end
         fsce_pkg::ST_WALK_START: begin
            state_in = fsce_pkg::ST_WALK;
         end
         fsce_pkg::ST_WALK: begin
            if (!walk_more) begin
               state_in = (func_ff == fsce_pkg::FUNC_REMOVE) ? fsce_pkg::ST_RESP
                                                             : fsce_pkg::ST_CALC;
            end
         end
         fsce_pkg::ST_CALC: begin
            state_in = fsce_pkg::ST_RESP;
         end
         fsce_pkg::ST_RESP: begin
            if (rsp_ready) begin
               state_in = fsce_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fsce_pkg::ST_IDLE;
         end
      endcase
   end

   // table port and handshake outputs
   always_comb begin
      tbl_wr    = '0;
      tbl_raddr = cur_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         fsce_pkg::ST_CLEAR: begin
            tbl_wr.en   = 1'b1;
            tbl_wr.addr = clr_ff;
         end
         fsce_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         fsce_pkg::ST_PUT_NEW: begin
            tbl_wr.en   = 1'b1;
            tbl_wr.addr = pos_ff[fsce_pkg::POS_W-1:0];
         end
         fsce_pkg::ST_PUT_LINK: begin
            tbl_wr.en            = 1'b1;
            tbl_wr.addr          = tail_pos_ff;
            tbl_wr.data.has_next = 1'b1;
            tbl_wr.data.next     = pos_ff[fsce_pkg::POS_W-1:0];
         end
         fsce_pkg::ST_WALK_START: begin
            tbl_raddr = start_ff;
         end
         fsce_pkg::ST_WALK: begin
            tbl_raddr = tbl_rd.next;
            if (func_ff == fsce_pkg::FUNC_REMOVE) begin
               tbl_wr.en   = 1'b1;
               tbl_wr.addr = cur_ff;
            end
         end
         fsce_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            tbl_wr = '0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      clr_in        = clr_ff;
      func_in       = func_ff;
      fid_in        = fid_ff;
      pos_in        = pos_ff;
      eof_in        = eof_ff;
      found_in      = found_ff;
      start_in      = start_ff;
      cur_in        = cur_ff;
      len_in        = len_ff;
      ok_in         = ok_ff;
      rtime_in      = rtime_ff;
      tail_valid_in = tail_valid_ff;
      tail_pos_in   = tail_pos_ff;
      dir_valid_in  = dir_valid_ff;
      tps_in        = csr_write_enable ? csr_write_data : tps_ff;

      if (state_ff == fsce_pkg::ST_CLEAR) begin
         clr_in = clr_ff + 1'b1;
      end
      if (accept) begin
         func_in  = fsce_pkg::func_type'(req_func);
         fid_in   = req_file_id;
         pos_in   = fsce_pkg::RAW_POS_W'(fsce_pkg::SECTORS_PER_CYLINDER * req_cylinder +
                                         fsce_pkg::SECTORS_PER_TRACK * req_track +
                                         req_sector_in_track);
         eof_in   = req_last_sector && (fsce_pkg::func_type'(req_func) == fsce_pkg::FUNC_APPEND);
         len_in   = '0;
         rtime_in = '0;
      end
      if (state_ff == fsce_pkg::ST_LOOKUP) begin
         found_in = found_now;
         start_in = found_now ? dir_rd_ff : '0;
         case (func_ff)
            fsce_pkg::FUNC_CREATE: ok_in = !found_now && pos_ok;
            fsce_pkg::FUNC_APPEND: ok_in = pos_ok;
            default:               ok_in = found_now;
         endcase
         if (dir_we) begin
            dir_valid_in[fid_ff] = 1'b1;
         end
         if ((func_ff == fsce_pkg::FUNC_REMOVE) && found_now) begin
            dir_valid_in[fid_ff] = 1'b0;
         end
      end
      if (tail_upd) begin
         tail_valid_in = !eof_ff;
         tail_pos_in   = pos_ff[fsce_pkg::POS_W-1:0];
      end
      if (state_ff == fsce_pkg::ST_WALK_START) begin
         cur_in = start_ff;
      end
      if (state_ff == fsce_pkg::ST_WALK) begin
         cur_in = tbl_rd.next;
         len_in = len_next[fsce_pkg::LEN_W-1:0];
      end
      if (state_ff == fsce_pkg::ST_CALC) begin
         rtime_in = fsce_pkg::TIME_W'(len_next) * fsce_pkg::TIME_W'(tps_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fsce_pkg::ST_CLEAR;
         clr_ff        <= '0;
         tail_valid_ff <= 1'b0;
         tail_pos_ff   <= '0;
         tps_ff        <= fsce_pkg::TPS_RESET;
         dir_valid_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         tail_valid_ff <= tail_valid_in;
         tail_pos_ff   <= tail_pos_in;
         tps_ff        <= tps_in;
         dir_valid_ff  <= dir_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      fid_ff   <= fid_in;
      pos_ff   <= pos_in;
      eof_ff   <= eof_in;
      found_ff <= found_in;
      start_ff <= start_in;
      cur_ff   <= cur_in;
      len_ff   <= len_in;
      ok_ff    <= ok_in;
      rtime_ff <= rtime_in;
   end

   always_ff @(posedge clock) begin
      if (dir_we) begin
         dir_mem_ff[fid_ff] <= pos_ff[fsce_pkg::POS_W-1:0];
      end
      dir_rd_ff <= dir_mem_ff[req_file_id];
   end

   assign rsp_ok             = ok_ff;
   assign rsp_found          = found_ff;
   assign rsp_start_position = start_ff;
   assign rsp_chain_length   = (func_ff == fsce_pkg::FUNC_QUERY) ? len_ff : '0;
   assign rsp_read_time      = rtime_ff;

endmodule
